// ===== design/escaped_frame_receiver_core_defines.svh =====
// ----------------------------------------------------------------------------
// Escaped frame receiver assertion macros
// Shared concurrent assertion helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define EFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define EFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define EFR_ASSERT_IMPL(label, ante, cons)
`define EFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared widths, codes, register indexes and the command type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efr_pkg;

  localparam int BYTE_W          = 8;
  localparam int KIND_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int FRAME_DEPTH_DEF = 64;

  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NACK  = 2'd2;

  localparam logic [BYTE_W-1:0] MARK_DELIVERED = 8'hFF;
  localparam logic [BYTE_W-1:0] MARK_NONE      = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NACK   = 3'd4;

  // Control bytes that the front end matches against.
  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] ack_code;
    logic [BYTE_W-1:0] nack_code;
  } codes_t;

  // One job for the back end: an ack, a nack, or a frame of len payload bytes.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] len;
  } cmd_t;

endpackage

// ===== design/efr_in_if.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver input channel
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface efr_in_if;
  import efr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/efr_out_if.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver result channel
// Valid/ready channel carrying one frame byte or ack/nack result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface efr_out_if;
  import efr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;
  logic              last_item;

  modport source (output valid, output kind, output data_byte, output last_item,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input last_item,
                  output ready);
endinterface

// ===== design/efr_store.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver frame store
// Single write port, single registered read port byte memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efr_store #(
  parameter int DEPTH = efr_pkg::FRAME_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [efr_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [efr_pkg::BYTE_W-1:0] rdata
);
  import efr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/efr_front.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver front end
// Takes bytes, tracks escape and ack state, fills the store, queues jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efr_front #(
  parameter int DEPTH = efr_pkg::FRAME_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  efr_in_if.sink                     in_ch,
  input  efr_pkg::codes_t            codes,
  input  logic                       q_full,
  output logic                       q_push,
  output efr_pkg::cmd_t              q_cmd,
  input  logic                       frame_done,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [efr_pkg::BYTE_W-1:0] mem_wdata
);
  import efr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     fill_r, fill_nxt;
  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic              wait_r, wait_nxt;
  logic              pend_r, pend_nxt;
  logic              accept;
  logic              store_req;
  logic [BYTE_W-1:0] b;

  // The store is being read while a frame job is outstanding, so no new
  // byte is taken until the back end has fetched the last payload byte.
  assign in_ch.ready = !pend_r && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  always_comb begin
    fill_nxt  = fill_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    wait_nxt  = wait_r;
    pend_nxt  = pend_r;
    store_req = 1'b0;
    q_push    = 1'b0;
    q_cmd     = '0;
    mem_we    = 1'b0;
    mem_waddr = fill_r[AW-1:0];
    mem_wdata = b;

    if (frame_done) begin
      pend_nxt = 1'b0;
    end

    if (accept) begin
      if (wait_r) begin
        if (b != codes.escape_code && prev_r == codes.ack_code) begin
          q_push     = 1'b1;
          q_cmd.kind = KIND_ACK;
          prev_nxt   = MARK_NONE;
          wait_nxt   = 1'b0;
        end else if (b != codes.escape_code && prev_r == codes.nack_code) begin
          q_push     = 1'b1;
          q_cmd.kind = KIND_NACK;
          prev_nxt   = MARK_NONE;
          wait_nxt   = 1'b0;
        end
      end else if ((b == codes.ack_code || b == codes.nack_code)
                   && prev_r == MARK_DELIVERED) begin
        wait_nxt = 1'b1;
        prev_nxt = b;
      end else if (b == codes.end_code && prev_r != codes.escape_code) begin
        if (fill_r != '0 && first_r == codes.start_code) begin
          q_push     = 1'b1;
          q_cmd.kind = KIND_FRAME;
          q_cmd.len  = BYTE_W'(fill_r - CW'(1));
          prev_nxt   = MARK_DELIVERED;
          pend_nxt   = 1'b1;
        end
        fill_nxt = '0;
      end else if (b == codes.escape_code && prev_r != codes.escape_code) begin
        prev_nxt = b;
      end else if (b == codes.escape_code) begin
        store_req = 1'b1;
        prev_nxt  = MARK_NONE;
      end else begin
        store_req = 1'b1;
        prev_nxt  = (b == MARK_DELIVERED) ? MARK_NONE : b;
      end
    end

    // A byte past the end of the store is dropped.
    if (store_req && fill_r < CW'(DEPTH)) begin
      mem_we   = 1'b1;
      fill_nxt = fill_r + CW'(1);
      if (fill_r == '0) begin
        first_nxt = b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      prev_r <= MARK_NONE;
      wait_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      prev_r <= prev_nxt;
      wait_r <= wait_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

endmodule

// ===== design/efr_queue.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver job queue
// Two-entry FIFO of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "escaped_frame_receiver_core_defines.svh"

module efr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  efr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output efr_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);
  import efr_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `EFR_ASSERT_IMPL(a_no_push_when_full, push, !full)

endmodule

// ===== design/efr_back.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver back end
// Runs queued jobs: ack/nack results and frame drains from the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "escaped_frame_receiver_core_defines.svh"

module efr_back #(
  parameter int DEPTH = efr_pkg::FRAME_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  efr_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [efr_pkg::BYTE_W-1:0] mem_rdata,
  output logic                       frame_done,
  efr_out_if.source                  out_ch
);
  import efr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DATA = 1'b1;

  logic              state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              last_r, last_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     len_r, len_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    q_pop         = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    frame_done    = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          kind_nxt      = q_cmd.kind;
          if (q_cmd.kind == KIND_FRAME) begin
            data_nxt = q_cmd.len;
            last_nxt = (q_cmd.len == '0);
            if (q_cmd.len == '0) begin
              frame_done = 1'b1;
            end else begin
              len_nxt   = AW'(q_cmd.len);
              idx_nxt   = AW'(1);
              mem_re    = 1'b1;
              mem_raddr = AW'(1);
              state_nxt = ST_DATA;
            end
          end else begin
            data_nxt = MARK_NONE;
            last_nxt = 1'b1;
          end
        end
      end
      ST_DATA: begin
        // The read data register holds until the next read, so a stall
        // simply waits here with the fetched byte in place.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_FRAME;
          data_nxt      = mem_rdata;
          last_nxt      = (idx_r == len_r);
          if (idx_r == len_r) begin
            frame_done = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            mem_re    = 1'b1;
            mem_raddr = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    len_r  <= len_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.data_byte = data_r;
  assign out_ch.last_item = last_r;

  `EFR_ASSERT_IMPL(a_idx_in_frame, state_r == ST_DATA, idx_r != '0 && idx_r <= len_r)
  `EFR_ASSERT_IMPL(a_ack_shape, out_valid_r && kind_r != KIND_FRAME,
                   data_r == MARK_NONE && last_r)
  `EFR_ASSERT_NEXT(a_drain_holds, state_r == ST_DATA && !slot_free,
                   state_r == ST_DATA && $stable(idx_r))

endmodule

// ===== design/escaped_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver core
// STX/ETX byte-stuffing deframer with ack/nack detection.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on in_ch, one per beat. Results leave on out_ch
// as beats of {kind, data_byte, last_item}: a delivered frame gives its
// payload length and then its payload bytes, the final beat marked by
// last_item; an ack or nack gives one beat with data_byte zero and last_item
// set. The five control bytes are written through cfg_we/cfg_idx/cfg_wdata
// while the block is idle; an index beyond the list is ignored.
// Flow: after a byte that stores, escapes or arms an ack wait, in_ch.ready
// stays high for the next beat. A byte that produces results pushes a job
// into the job queue; the back end pops it into the result register, from
// which the first beat goes out on out_ch once the result slot is free.
// A frame drains as its length beat and then its payload bytes, one beat per
// cycle while out_ch is ready, from the single read port of the frame store;
// in_ch is held off until the last payload byte has been fetched.
// Reset clears the fill count, escape and ack state, the job queue and the
// result valid flag; the store itself is not cleared and needs no sweep.
// When out_ch stalls, the result register holds its beat, the drain waits,
// and in_ch stalls once the two-entry job queue is full or a drain is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escaped_frame_receiver_core #(
  parameter int FRAME_DEPTH = efr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  efr_in_if.sink                        in_ch,
  efr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [efr_pkg::BYTE_W-1:0]    cfg_wdata
);
  import efr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);

  codes_t            codes_r, codes_nxt;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  cmd_t              push_cmd;
  cmd_t              head_cmd;
  logic              frame_done;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // Control byte registers, decoded by index.
  always_comb begin
    codes_nxt = codes_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_START:  codes_nxt.start_code  = cfg_wdata;
        REG_END:    codes_nxt.end_code    = cfg_wdata;
        REG_ESCAPE: codes_nxt.escape_code = cfg_wdata;
        REG_ACK:    codes_nxt.ack_code    = cfg_wdata;
        REG_NACK:   codes_nxt.nack_code   = cfg_wdata;
        default:    codes_nxt = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.start_code  <= 8'd2;
      codes_r.end_code    <= 8'd3;
      codes_r.escape_code <= 8'd27;
      codes_r.ack_code    <= 8'd6;
      codes_r.nack_code   <= 8'd21;
    end else begin
      codes_r <= codes_nxt;
    end
  end

  efr_front #(
    .DEPTH (FRAME_DEPTH),
    .AW    (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .codes      (codes_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .frame_done (frame_done),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  efr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  efr_store #(
    .DEPTH (FRAME_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  efr_back #(
    .DEPTH (FRAME_DEPTH),
    .AW    (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .frame_done (frame_done),
    .out_ch     (out_ch)
  );

endmodule
